@@ design/sdbs_pkg.sv @@
// Shared constants, codes and the command type of the sorted dictionary search block.
package sdbs_pkg;

	localparam int TABLE_ENTRIES  = 4096;
	localparam int ENTRY_W        = $clog2(TABLE_ENTRIES);
	localparam int COUNT_W        = ENTRY_W + 1;
	localparam int STRING_BYTES   = 64;
	localparam int BYTES_PER_WORD = 8;
	localparam int STRING_WORDS   = STRING_BYTES / BYTES_PER_WORD;
	localparam int WORD_IDX_W     = $clog2(STRING_WORDS);
	localparam int DATA_W         = 64;

	localparam logic [WORD_IDX_W-1:0] WORD_LAST = WORD_IDX_W'(STRING_WORDS - 1);

	localparam logic [1:0] OP_KEY  = 2'd0;
	localparam logic [1:0] OP_TGT  = 2'd1;
	localparam logic [1:0] OP_QRY  = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	typedef logic [STRING_WORDS-1:0][DATA_W-1:0] string_t;

	typedef struct packed {
		logic [1:0]            kind;
		logic [ENTRY_W-1:0]    entry;
		logic [WORD_IDX_W-1:0] word;
		logic [DATA_W-1:0]     data;
	} cmd_t;

endpackage

@@ design/sdbs_front.sv @@
// Front end: accepts input transactions, drops unused codes and queues commands.
module sdbs_front
	import sdbs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            op,
	input  logic [ENTRY_W-1:0]    entry_index,
	input  logic [WORD_IDX_W-1:0] word_index,
	input  logic [DATA_W-1:0]     word_data,
	output logic                  cmd_valid,
	output cmd_t                  cmd,
	input  logic                  cmd_pop
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = PTR_W + 1;

	cmd_t             queue_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             useful;

	// Op three carries no work; it is accepted and dropped here.
	assign useful    = op inside {OP_KEY, OP_TGT, OP_QRY};
	assign in_ready  = (count_q != CNT_W'(DEPTH));
	assign push      = in_valid && in_ready && useful;
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push && cmd_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{kind: op, entry: entry_index, word: word_index,
				data: word_data};
		end
	end

endmodule

@@ design/sdbs_back.sv @@
// Back end: table memories, query buffer, binary search sequencer and result output.
module sdbs_back
	import sdbs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [COUNT_W-1:0]    cfg_wdata,
	input  logic                  cmd_valid,
	input  cmd_t                  cmd,
	output logic                  cmd_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [WORD_IDX_W-1:0] out_word_index,
	output logic [DATA_W-1:0]     out_data,
	output logic                  found,
	output logic                  last
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SEARCH   = 3'd1;
	localparam logic [2:0] ST_KEY_WAIT = 3'd2;
	localparam logic [2:0] ST_DECIDE   = 3'd3;
	localparam logic [2:0] ST_EMIT     = 3'd4;

	string_t key_mem [TABLE_ENTRIES];
	string_t tgt_mem [TABLE_ENTRIES];
	string_t key_rd_q;
	string_t tgt_rd_q;

	logic [DATA_W-1:0]       qbuf_q [STRING_WORDS];
	logic [COUNT_W-1:0]      entry_count_q;
	logic [COUNT_W-1:0]      count_cap;
	logic [2:0]              state_q;
	logic [COUNT_W-1:0]      lo_q;
	logic [COUNT_W-1:0]      hi_q;
	logic [COUNT_W-1:0]      mid_full;
	logic [ENTRY_W-1:0]      mid_q;
	logic [STRING_WORDS-1:0] cmp_lt_q;
	logic [STRING_WORDS-1:0] cmp_eq_q;
	logic [STRING_WORDS-1:0] cmp_lt;
	logic [STRING_WORDS-1:0] cmp_eq;
	logic                    key_less;
	logic                    key_match;
	logic                    found_q;
	logic [WORD_IDX_W-1:0]   emit_idx_q;
	logic                    ended_q;
	logic                    ended_n;
	logic [DATA_W-1:0]       src_word;
	logic [DATA_W-1:0]       shaped;
	logic [7:0]              cur_byte;
	logic                    key_we;
	logic                    tgt_we;
	logic                    key_re;
	logic                    tgt_re;
	logic                    out_load;

	logic                    out_valid_q;
	logic [WORD_IDX_W-1:0]   out_word_index_q;
	logic [DATA_W-1:0]       out_data_q;
	logic                    out_found_q;
	logic                    out_last_q;

	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign key_we    = cmd_pop && (cmd.kind == OP_KEY);
	assign tgt_we    = cmd_pop && (cmd.kind == OP_TGT);
	assign key_re    = (state_q == ST_SEARCH) && (lo_q < hi_q);
	assign tgt_re    = (state_q == ST_DECIDE) && key_match;
	assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign count_cap = (entry_count_q > COUNT_W'(TABLE_ENTRIES)) ?
		COUNT_W'(TABLE_ENTRIES) : entry_count_q;
	// Lower midpoint of the half-open range [lo, hi).
	assign mid_full  = lo_q + ((hi_q - lo_q - COUNT_W'(1)) >> 1);

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[cmd.entry][cmd.word] <= cmd.data;
		end
		if (key_re) begin
			key_rd_q <= key_mem[mid_full[ENTRY_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (tgt_we) begin
			tgt_mem[cmd.entry][cmd.word] <= cmd.data;
		end
		if (tgt_re) begin
			tgt_rd_q <= tgt_mem[mid_q];
		end
	end

	always_comb begin
		for (int i = 0; i < STRING_WORDS; i++) begin
			cmp_lt[i] = qbuf_q[i] < key_rd_q[i];
			cmp_eq[i] = qbuf_q[i] == key_rd_q[i];
		end
	end

	// Word zero is most significant, so the lowest differing word decides.
	always_comb begin
		key_match = &cmp_eq_q;
		key_less  = 1'b0;
		for (int i = STRING_WORDS - 1; i >= 0; i--) begin
			if (!cmp_eq_q[i]) begin
				key_less = cmp_lt_q[i];
			end
		end
	end

	// Bytes after the first zero byte, and the final byte of the string, go out as zero.
	always_comb begin
		src_word = found_q ? tgt_rd_q[emit_idx_q] : qbuf_q[emit_idx_q];
		ended_n  = ended_q;
		shaped   = '0;
		cur_byte = '0;
		for (int b = 0; b < BYTES_PER_WORD; b++) begin
			cur_byte = src_word[DATA_W-1-8*b -: 8];
			if (cur_byte == 8'd0 || (emit_idx_q == WORD_LAST && b == BYTES_PER_WORD - 1)) begin
				ended_n = 1'b1;
			end
			if (!ended_n) begin
				shaped[DATA_W-1-8*b -: 8] = cur_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			state_q       <= ST_IDLE;
			lo_q          <= '0;
			hi_q          <= '0;
			mid_q         <= '0;
			found_q       <= 1'b0;
			emit_idx_q    <= '0;
			ended_q       <= 1'b0;
			cmp_lt_q      <= '0;
			cmp_eq_q      <= '0;
			out_valid_q   <= 1'b0;
			for (int i = 0; i < STRING_WORDS; i++) begin
				qbuf_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				entry_count_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop && cmd.kind == OP_QRY) begin
						qbuf_q[cmd.word] <= cmd.data;
						if (cmd.word == WORD_LAST) begin
							lo_q    <= '0;
							hi_q    <= count_cap;
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid_full[ENTRY_W-1:0];
						state_q <= ST_KEY_WAIT;
					end else begin
						found_q    <= 1'b0;
						emit_idx_q <= '0;
						ended_q    <= 1'b0;
						state_q    <= ST_EMIT;
					end
				end
				ST_KEY_WAIT: begin
					cmp_lt_q <= cmp_lt;
					cmp_eq_q <= cmp_eq;
					state_q  <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (key_match) begin
						found_q    <= 1'b1;
						emit_idx_q <= '0;
						ended_q    <= 1'b0;
						state_q    <= ST_EMIT;
					end else begin
						if (key_less) begin
							hi_q <= {1'b0, mid_q};
						end else begin
							lo_q <= {1'b0, mid_q} + COUNT_W'(1);
						end
						state_q <= ST_SEARCH;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						emit_idx_q  <= emit_idx_q + WORD_IDX_W'(1);
						ended_q     <= ended_n;
						if (emit_idx_q == WORD_LAST) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_index_q <= emit_idx_q;
			out_data_q       <= shaped;
			out_found_q      <= found_q;
			out_last_q       <= (emit_idx_q == WORD_LAST);
		end
	end

	assign out_valid      = out_valid_q;
	assign out_word_index = out_word_index_q;
	assign out_data       = out_data_q;
	assign found          = out_found_q;
	assign last           = out_last_q;

	a_range_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH || state_q == ST_KEY_WAIT || state_q == ST_DECIDE)
		|-> (lo_q <= hi_q) && (hi_q <= COUNT_W'(TABLE_ENTRIES)))
		else $error("search bounds out of order");

	a_mid_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) |-> ({1'b0, mid_q} >= lo_q) && ({1'b0, mid_q} < hi_q))
		else $error("probe index outside the search range");

	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_EMIT))
		else $error("result word raised outside the emit state");

	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (out_word_index_q == WORD_LAST))
		else $error("last flag on a word other than the final one");

endmodule

@@ design/sorted_dictionary_binary_search.sv @@
// Top level of the sorted dictionary lookup: front end queue feeding the search back end.
// Load transactions write one 64-bit word of a key or target entry and are retired by the
// back end while it is idle. A query word is buffered in the back end; the final query word
// (index 7) starts a binary search over the first entry_count entries (at most 4096), where
// each probe passes a registered key memory read, a word-wise compare stage and a decision
// step, and a search is followed by eight result transactions, paced by out_ready. A
// four-entry command queue sits between the input port and the back end, so input
// transactions keep being accepted, until the queue is full, while a search or the result
// output is in progress. Write entry_count only while the block is idle; no clearing pass is
// needed after reset, since table entries must be loaded before they are searched.
module sorted_dictionary_binary_search
	import sdbs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [COUNT_W-1:0]    cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            op,
	input  logic [ENTRY_W-1:0]    entry_index,
	input  logic [WORD_IDX_W-1:0] word_index,
	input  logic [DATA_W-1:0]     word_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [WORD_IDX_W-1:0] out_word_index,
	output logic [DATA_W-1:0]     out_data,
	output logic                  found,
	output logic                  last
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	sdbs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.entry_index (entry_index),
		.word_index  (word_index),
		.word_data   (word_data),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop)
	);

	sdbs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.cmd_pop        (cmd_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_word_index (out_word_index),
		.out_data       (out_data),
		.found          (found),
		.last           (last)
	);

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the sorted dictionary binary search block.
module tb_top;
	import sdbs_pkg::*;

	localparam int STR_W          = STRING_BYTES * 8;
	localparam int COUNT_MAX      = (1 << COUNT_W) - 1;
	localparam int LOADED_ENTRIES = 8;

	typedef struct packed {
		logic [WORD_IDX_W-1:0] idx;
		logic [DATA_W-1:0]     data;
		logic                  found;
		logic                  last;
	} result_t;

	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [COUNT_W-1:0]    cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            op;
	logic [ENTRY_W-1:0]    entry_index;
	logic [WORD_IDX_W-1:0] word_index;
	logic [DATA_W-1:0]     word_data;
	logic                  out_valid;
	logic                  out_ready;
	logic [WORD_IDX_W-1:0] out_word_index;
	logic [DATA_W-1:0]     out_data;
	logic                  found;
	logic                  last;

	// Mirror of the block state; string word 0 sits in the top bits.
	logic [STR_W-1:0]   table_keys [TABLE_ENTRIES];
	logic [STR_W-1:0]   table_targets [TABLE_ENTRIES];
	logic [STR_W-1:0]   query_words = '0;
	logic [COUNT_W-1:0] entries_in_use = '0;
	result_t            expected_words [$];
	result_t            seen_word;
	result_t            want_word;

	int errors = 0;
	int inputs_seen = 0;
	int results_seen = 0;
	int searches = 0;
	int hits = 0;
	int count_writes = 0;
	int items_sent = 0;

	int        tx_gap_max = 0;
	int        tx_burst_left = 0;
	int        rx_hold_left = 0;
	rx_style_t rx_style = RX_ALWAYS;
	logic [15:0] rx_pat = 16'h5a5b;

	sorted_dictionary_binary_search dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.entry_index    (entry_index),
		.word_index     (word_index),
		.word_data      (word_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_word_index (out_word_index),
		.out_data       (out_data),
		.found          (found),
		.last           (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#1ms;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [DATA_W-1:0] word_of(logic [STR_W-1:0] s, int w);
		return s[STR_W-1-DATA_W*w -: DATA_W];
	endfunction

	// Bytes after the first zero byte read as zero, and the final byte is always zero.
	function automatic logic [STR_W-1:0] shape_string(logic [STR_W-1:0] s);
		logic [STR_W-1:0] r;
		logic ended;
		int i;
		r = '0;
		ended = 1'b0;
		for (i = 0; i < STRING_BYTES; i++) begin
			if (s[STR_W-1-8*i -: 8] == 8'h00 || i == STRING_BYTES - 1)
				ended = 1'b1;
			if (!ended)
				r[STR_W-1-8*i -: 8] = s[STR_W-1-8*i -: 8];
		end
		return r;
	endfunction

	function automatic int searched_entries();
		return (int'(entries_in_use) > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(entries_in_use);
	endfunction

	function automatic void search_table();
		logic [STR_W-1:0] src;
		logic hit;
		int lo, hi, mid, w;
		lo = 0;
		hi = searched_entries() - 1;
		hit = 1'b0;
		src = query_words;
		while (!hit && lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (query_words == table_keys[mid]) begin
				hit = 1'b1;
				src = table_targets[mid];
			end else if (query_words < table_keys[mid]) begin
				hi = mid - 1;
			end else begin
				lo = mid + 1;
			end
		end
		src = shape_string(src);
		searches++;
		if (hit)
			hits++;
		for (w = 0; w < STRING_WORDS; w++)
			expected_words.push_back('{WORD_IDX_W'(w), word_of(src, w), hit,
				w == STRING_WORDS - 1});
	endfunction

	function automatic void apply_transaction(logic [1:0] kind, logic [ENTRY_W-1:0] e,
			logic [WORD_IDX_W-1:0] w, logic [DATA_W-1:0] d);
		int base;
		base = STR_W - 1 - DATA_W * int'(w);
		case (kind)
			OP_KEY: table_keys[e][base -: DATA_W] = d;
			OP_TGT: table_targets[e][base -: DATA_W] = d;
			OP_QRY: begin
				query_words[base -: DATA_W] = d;
				if (w == WORD_LAST)
					search_table();
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				entries_in_use = cfg_wdata;
				count_writes++;
			end
			if (in_valid && in_ready) begin
				inputs_seen++;
				apply_transaction(op, entry_index, word_index, word_data);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_word = '{out_word_index, out_data, found, last};
			results_seen++;
			if (expected_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual idx=%0d data=%h found=%b last=%b",
					$time, seen_word.idx, seen_word.data, seen_word.found, seen_word.last);
			end else begin
				want_word = expected_words.pop_front();
				if (seen_word !== want_word) begin
					errors++;
					$display("%0t: result mismatch: expected idx=%0d data=%h found=%b last=%b",
						$time, want_word.idx, want_word.data, want_word.found, want_word.last);
					$display("%0t:                  actual   idx=%0d data=%h found=%b last=%b",
						$time, seen_word.idx, seen_word.data, seen_word.found, seen_word.last);
				end
			end
		end
	end

	// The receiver keeps its own stall pattern; a long hold is counted down here.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				out_ready <= 1'b0;
				rx_hold_left--;
			end else begin
				case (rx_style)
					RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
					RX_PATTERN: begin
						out_ready <= rx_pat[0];
						rx_pat = {rx_pat[0], rx_pat[15:1]};
					end
					default: out_ready <= 1'b1;
				endcase
			end
		end
	end

	task automatic send_item(input logic [1:0] kind, input logic [ENTRY_W-1:0] e,
			input logic [WORD_IDX_W-1:0] w, input logic [DATA_W-1:0] d);
		int gap;
		if (tx_gap_max > 0 && tx_burst_left <= 0) begin
			gap = $urandom_range(1, tx_gap_max);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			tx_burst_left = $urandom_range(1, 12);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		op <= kind;
		entry_index <= e;
		word_index <= w;
		word_data <= d;
		do @(posedge clk); while (!in_ready);
		tx_burst_left--;
		if (kind != OP_NONE)
			items_sent++;
	endtask

	// Drop valid, let every expected result drain, then allow in-flight loads to retire.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic configure(input int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= COUNT_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [STR_W-1:0] random_string();
		logic [STR_W-1:0] s;
		int p, i;
		for (i = 0; i < STRING_WORDS; i++)
			s[STR_W-1-DATA_W*i -: DATA_W] = {$urandom, $urandom};
		p = $urandom_range(0, STRING_BYTES - 1);
		case ($urandom_range(0, 5))
			0, 1: s[STR_W-1-8*p -: 8] = 8'h00;
			2, 3: begin
				for (i = p; i < STRING_BYTES; i++)
					s[STR_W-1-8*i -: 8] = 8'h00;
			end
			4: s = '1;
			default: ;
		endcase
		return s;
	endfunction

	task automatic send_string(input logic [STR_W-1:0] s);
		int w;
		for (w = 0; w < STRING_WORDS; w++)
			send_item(OP_QRY, ENTRY_W'($urandom), WORD_IDX_W'(w), word_of(s, w));
	endtask

	task automatic send_noise();
		int e, w;
		e = $urandom_range(0, LOADED_ENTRIES - 1);
		w = $urandom_range(0, STRING_WORDS - 1);
		case ($urandom_range(0, 7))
			0, 1: send_item(OP_NONE, ENTRY_W'($urandom), WORD_IDX_W'($urandom),
				{$urandom, $urandom});
			2: send_item(OP_KEY, ENTRY_W'(e), WORD_IDX_W'(w), {$urandom, $urandom});
			3, 4: send_item(OP_KEY, ENTRY_W'(e), WORD_IDX_W'(w), word_of(table_keys[e], w));
			default: send_item(OP_TGT, ENTRY_W'(e), WORD_IDX_W'(w), {$urandom, $urandom});
		endcase
	endtask

	// One lookup: a key from the table, a near miss or a random string. Words may arrive
	// out of order, only the changed words may be sent, and now and then the sequence is
	// abandoned before its final word.
	task automatic lookup_sequence();
		logic [STR_W-1:0] q;
		logic sparse;
		int n, e, k, j, t, pick;
		int order [STRING_WORDS-1];
		n = searched_entries();
		pick = $urandom_range(0, 9);
		e = 0;
		if (n > 0) begin
			if ($urandom_range(0, 3) == 0)
				e = $urandom_range(0, 1) ? 0 : n - 1;
			else
				e = $urandom_range(0, n - 1);
		end
		if (n > 0 && pick < 5)
			q = table_keys[e];
		else if (pick < 7)
			q = table_keys[e] ^ (STR_W'(1) << $urandom_range(0, STR_W - 1));
		else
			q = random_string();
		for (k = 0; k < STRING_WORDS - 1; k++)
			order[k] = k;
		if ($urandom_range(0, 2) == 0) begin
			for (k = STRING_WORDS - 2; k > 0; k--) begin
				j = $urandom_range(0, k);
				t = order[k];
				order[k] = order[j];
				order[j] = t;
			end
		end
		sparse = ($urandom_range(0, 3) == 0);
		for (k = 0; k < STRING_WORDS - 1; k++) begin
			if (!sparse || word_of(q, order[k]) != word_of(query_words, order[k]))
				send_item(OP_QRY, ENTRY_W'($urandom), WORD_IDX_W'(order[k]),
					word_of(q, order[k]));
			if ($urandom_range(0, 15) == 0)
				send_noise();
		end
		if ($urandom_range(0, 9) != 0)
			send_item(OP_QRY, ENTRY_W'($urandom), WORD_LAST, word_of(q, STRING_WORDS - 1));
	endtask

	task automatic test_empty_table();
		configure(0);
		// Only the final word: the other words still hold their reset value of zero.
		send_item(OP_QRY, '1, WORD_LAST, '1);
		send_item(OP_NONE, '1, '1, '1);
		send_string('1);
		send_item(OP_NONE, '0, '0, '0);
	endtask

	// Fills the low entries with strictly increasing keys, all zero first. Every entry that
	// a search over the whole table probes above them gets an all-ones key, so a query no
	// larger than the last low key only ever reads loaded entries.
	task automatic load_table();
		logic [STR_W-1:0] k, t;
		int e, w, g;
		tx_gap_max = 0;
		k = '0;
		for (e = 0; e < LOADED_ENTRIES; e++) begin
			if (e > 0)
				k = k + (STR_W'($urandom | 32'd1) << (8 * $urandom_range(0, STRING_BYTES - 8)));
			t = random_string();
			for (w = 0; w < STRING_WORDS; w++)
				send_item(OP_KEY, ENTRY_W'(e), WORD_IDX_W'(w), word_of(k, w));
			for (w = 0; w < STRING_WORDS; w++)
				send_item(OP_TGT, ENTRY_W'(e), WORD_IDX_W'(w), word_of(t, w));
		end
		for (g = 2 * LOADED_ENTRIES - 1; g < TABLE_ENTRIES - 1; g = 2 * g + 1) begin
			for (w = 0; w < STRING_WORDS; w++)
				send_item(OP_KEY, ENTRY_W'(g), WORD_IDX_W'(w), '1);
		end
	endtask

	task automatic test_count_extremes();
		settle();
		configure(1);
		send_string(table_keys[0]);
		settle();
		configure(COUNT_MAX);
		send_string(table_keys[LOADED_ENTRIES - 1]);
	endtask

	task automatic test_backpressure();
		int k;
		settle();
		configure(TABLE_ENTRIES);
		tx_gap_max = 0;
		rx_style = RX_ALWAYS;
		rx_hold_left = 300;
		for (k = 0; k < 4; k++)
			send_string(table_keys[$urandom_range(0, LOADED_ENTRIES - 1)]);
	endtask

	task automatic test_random_lookups();
		int start, k, entries;
		start = items_sent;
		while (items_sent - start < 100) begin
			settle();
			case ($urandom_range(0, 5))
				0: entries = 0;
				1: entries = 1;
				2: entries = 2;
				3: entries = LOADED_ENTRIES;
				default: entries = $urandom_range(3, LOADED_ENTRIES - 1);
			endcase
			configure(entries);
			case ($urandom_range(0, 2))
				0: rx_style = RX_ALWAYS;
				1: rx_style = RX_RANDOM;
				default: begin
					rx_style = RX_PATTERN;
					rx_pat = 16'($urandom) | 16'h0001;
				end
			endcase
			tx_gap_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
			for (k = 0; k < 6; k++) begin
				lookup_sequence();
				if ($urandom_range(0, 3) == 0)
					send_noise();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		op = OP_NONE;
		entry_index = '0;
		word_index = '0;
		word_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		load_table();
		test_count_extremes();
		test_backpressure();
		test_random_lookups();
		settle();

		$display("Covered %0d input transactions and %0d result transactions from %0d searches.",
			inputs_seen, results_seen, searches);
		$display("%0d searches matched a key; entry_count was written %0d times.",
			hits, count_writes);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
